>>> rtl/ggpm_pkg.sv
// ggpm_pkg: shared types and constants for the gated greedy point matcher
// word layouts, action codes, control state codes and cell control group
// no dependencies
`default_nettype none

package ggpm_pkg;

  localparam int FIELD_W   = 16;
  localparam int IDX_OUT_W = 8;
  localparam int GATE_W    = 33;

  localparam logic [GATE_W-1:0] GATE_RESET = 33'd65536;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_MATCH = 2'd2;

  // last drain count value, while the distance unit empties after the last probe
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [FIELD_W-1:0] point_x;
    logic [FIELD_W-1:0] point_y;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] corner_index;
    logic [FIELD_W-1:0]   match_x;
    logic [FIELD_W-1:0]   match_y;
    logic                 run_done;
    logic                 all_matched;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic clear_used;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/gated_greedy_point_matcher_top.sv
// gated_greedy_point_matcher_top: corner store ring, control and result register
// instantiates ggpm_cell (one per corner slot) and ggpm_dist
// depends on ggpm_pkg
//
//   channel  valid      stall      word        dir
//   input    in_valid   in_stall   in_word     in
//   result   out_valid  out_stall  out_word    out
//   config   cfg_we     -          cfg_data    in
//
// clear and load give no word
// a match rotates the ring once past the single distance pipeline at the head cell;
// an aborted match skips the scan and drain and goes straight to finish
// one item at a time; a new item is taken while a result word still waits
// rst is synchronous and clears control state and used marks, not corner data
`default_nettype none

module gated_greedy_point_matcher_top
  import ggpm_pkg::*;
#(
  parameter int MAX_CORNERS = 256,
  parameter int COORD_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_word,
  input  wire logic              cfg_we,
  input  wire logic [GATE_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_CORNERS);
  localparam int CNT_W = $clog2(MAX_CORNERS + 1);

  state_t                state, state_next;
  logic [IDX_W-1:0]      scan_cnt;
  logic [1:0]            drain_cnt;
  logic [CNT_W-1:0]      corner_count;
  logic                  run_aborted;
  logic [GATE_W-1:0]     gate;
  logic [COORD_BITS-1:0] pt_x, pt_y;
  logic                  pt_last;

  logic accept, emit, scan_last, has_room, do_load, do_clear, do_match, probe_valid;
  cell_ctrl_t ctrl;

  logic [COORD_BITS-1:0] cell_x [MAX_CORNERS];
  logic [COORD_BITS-1:0] cell_y [MAX_CORNERS];
  logic                  cell_used [MAX_CORNERS];

  logic                  best_hit;
  logic [IDX_W-1:0]      best_idx;
  logic [COORD_BITS-1:0] best_x, best_y;

  always_comb begin
    in_stall    = (state != ST_IDLE);
    accept      = in_valid && !in_stall;
    do_clear    = accept && (in_word.action == ACT_CLEAR);
    do_load     = accept && (in_word.action == ACT_LOAD);
    do_match    = accept && (in_word.action == ACT_MATCH);
    has_room    = corner_count < CNT_W'(MAX_CORNERS);
    scan_last   = (scan_cnt == IDX_W'(MAX_CORNERS - 1));
    probe_valid = (state == ST_SCAN) && (CNT_W'(scan_cnt) < corner_count) && !cell_used[0];
    emit        = 1'b0;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        if (do_match) begin
          state_next = run_aborted ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == DRAIN_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ctrl.shift      = (state == ST_SCAN);
    ctrl.clear_used = do_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_cnt     <= '0;
      drain_cnt    <= '0;
      corner_count <= '0;
      run_aborted  <= 1'b0;
      gate         <= GATE_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        gate <= cfg_data;
      end
      if (do_clear) begin
        corner_count <= '0;
        run_aborted  <= 1'b0;
      end else if (do_load && has_room) begin
        corner_count <= corner_count + CNT_W'(1);
      end
      if (state == ST_SCAN) begin
        scan_cnt <= scan_last ? '0 : scan_cnt + IDX_W'(1);
      end
      if (state == ST_DRAIN) begin
        drain_cnt <= (drain_cnt == DRAIN_LAST) ? 2'd0 : drain_cnt + 2'd1;
      end
      if (emit) begin
        out_valid   <= 1'b1;
        run_aborted <= run_aborted || !best_hit;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_match) begin
      pt_x    <= COORD_BITS'(in_word.point_x);
      pt_y    <= COORD_BITS'(in_word.point_y);
      pt_last <= in_word.last_point;
    end
    if (emit) begin
      out_word.found        <= best_hit;
      out_word.corner_index <= best_hit ? IDX_OUT_W'(best_idx) : '0;
      out_word.match_x      <= best_hit ? FIELD_W'(best_x) : '0;
      out_word.match_y      <= best_hit ? FIELD_W'(best_y) : '0;
      out_word.run_done     <= pt_last;
      out_word.all_matched  <= pt_last && !run_aborted && best_hit;
    end
  end

  for (genvar i = 0; i < MAX_CORNERS; i++) begin : g_cell
    ggpm_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .load_en  (do_load && has_room && (corner_count == CNT_W'(i))),
      .mark_en  (emit && best_hit && (best_idx == IDX_W'(i))),
      .load_x   (COORD_BITS'(in_word.point_x)),
      .load_y   (COORD_BITS'(in_word.point_y)),
      .nbr_x    (cell_x[(i + 1) % MAX_CORNERS]),
      .nbr_y    (cell_y[(i + 1) % MAX_CORNERS]),
      .nbr_used (cell_used[(i + 1) % MAX_CORNERS]),
      .x        (cell_x[i]),
      .y        (cell_y[i]),
      .used     (cell_used[i])
    );
  end

  ggpm_dist #(
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IDX_W)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .start      (do_match),
    .probe_valid(probe_valid),
    .probe_idx  (scan_cnt),
    .probe_x    (cell_x[0]),
    .probe_y    (cell_y[0]),
    .ref_x      (pt_x),
    .ref_y      (pt_y),
    .gate       (gate),
    .best_hit   (best_hit),
    .best_idx   (best_idx),
    .best_x     (best_x),
    .best_y     (best_y)
  );

  a_word_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result word raised outside finish");

  a_found_keeps_run: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_word.found) |-> !run_aborted)
    else $error("run aborted after a successful match");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    do_load && !has_room |=> corner_count == CNT_W'(MAX_CORNERS))
    else $error("load into full store changed count");

  a_ring_realigned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && $past(state == ST_SCAN)) |-> scan_cnt == '0)
    else $error("ring not back in place after scan");

endmodule

`default_nettype wire

>>> rtl/ggpm_cell.sv
// ggpm_cell: one corner slot of the rotating store ring
// holds x, y and the used mark, takes its neighbor's contents on a shift
// depends on ggpm_pkg
`default_nettype none

module ggpm_cell
  import ggpm_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic                  load_en,
  input  wire logic                  mark_en,
  input  wire logic [COORD_BITS-1:0] load_x,
  input  wire logic [COORD_BITS-1:0] load_y,
  input  wire logic [COORD_BITS-1:0] nbr_x,
  input  wire logic [COORD_BITS-1:0] nbr_y,
  input  wire logic                  nbr_used,
  output logic      [COORD_BITS-1:0] x,
  output logic      [COORD_BITS-1:0] y,
  output logic                       used
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      x <= nbr_x;
      y <= nbr_y;
    end else if (load_en) begin
      x <= load_x;
      y <= load_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clear_used) begin
      used <= 1'b0;
    end else if (ctrl.shift) begin
      used <= nbr_used;
    end else if (mark_en) begin
      used <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ggpm_dist.sv
// ggpm_dist: pipelined squared distance unit with nearest candidate tracking
// stages: probe capture, absolute differences, squares, sum with gate and best compare
// depends on ggpm_pkg
`default_nettype none

module ggpm_dist
  import ggpm_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  probe_valid,
  input  wire logic [IDX_W-1:0]      probe_idx,
  input  wire logic [COORD_BITS-1:0] probe_x,
  input  wire logic [COORD_BITS-1:0] probe_y,
  input  wire logic [COORD_BITS-1:0] ref_x,
  input  wire logic [COORD_BITS-1:0] ref_y,
  input  wire logic [GATE_W-1:0]     gate,
  output logic                       best_hit,
  output logic      [IDX_W-1:0]      best_idx,
  output logic      [COORD_BITS-1:0] best_x,
  output logic      [COORD_BITS-1:0] best_y
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;
  localparam int CMP_W  = (DIST_W > GATE_W) ? DIST_W : GATE_W;

  logic                  a_valid, b_valid, c_valid;
  logic [IDX_W-1:0]      a_idx, b_idx, c_idx;
  logic [COORD_BITS-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
  logic [COORD_BITS-1:0] b_dx, b_dy;
  logic [SQ_W-1:0]       c_sqx, c_sqy;
  logic [DIST_W-1:0]     best_d;
  logic [DIST_W-1:0]     sum;
  logic                  take;

  always_comb begin
    sum  = DIST_W'(c_sqx) + DIST_W'(c_sqy);
    take = c_valid && (CMP_W'(sum) < CMP_W'(gate)) && (!best_hit || sum < best_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      best_hit <= 1'b0;
    end else begin
      a_valid <= probe_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      if (start) begin
        best_hit <= 1'b0;
      end else if (take) begin
        best_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx <= probe_idx;
    a_x   <= probe_x;
    a_y   <= probe_y;
    b_idx <= a_idx;
    b_x   <= a_x;
    b_y   <= a_y;
    b_dx  <= (a_x >= ref_x) ? (a_x - ref_x) : (ref_x - a_x);
    b_dy  <= (a_y >= ref_y) ? (a_y - ref_y) : (ref_y - a_y);
    c_idx <= b_idx;
    c_x   <= b_x;
    c_y   <= b_y;
    c_sqx <= SQ_W'(b_dx) * SQ_W'(b_dx);
    c_sqy <= SQ_W'(b_dy) * SQ_W'(b_dy);
    if (take) begin
      best_d   <= sum;
      best_idx <= c_idx;
      best_x   <= c_x;
      best_y   <= c_y;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb.sv
// tb: self-checking bench for gated_greedy_point_matcher_top
// sends clear, load, match and unused action words with random gaps and stalls, predicts each
// match word in a local corner store model; depends on ggpm_pkg and the rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ggpm_pkg::*;

  localparam int CORNERS     = 256;
  localparam int SETTLE      = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int ITEM_TARGET = 1500;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [GATE_W-1:0] GATE_ALL = {GATE_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [GATE_W-1:0] cfg_data = '0;
  in_word_t in_word = '0;
  logic in_stall;
  logic out_valid;
  out_word_t out_word;

  // local copy of the corner store
  logic [FIELD_W-1:0] corner_x [CORNERS];
  logic [FIELD_W-1:0] corner_y [CORNERS];
  bit corner_used [CORNERS];
  int corner_cnt = 0;
  bit run_aborted = 1'b0;
  logic [GATE_W-1:0] gate_sqr = GATE_RESET;
  out_word_t expected_matches[$];
  out_word_t want_word;

  bit gaps_on = 1'b1;
  int n_words = 0;
  int n_results = 0;
  int n_found = 0;
  int n_gates = 0;
  int n_errors = 0;
  int quiet_cycles = 0;

  gated_greedy_point_matcher_top #(
    .MAX_CORNERS(CORNERS),
    .COORD_BITS (FIELD_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_matches.size() == 0) begin
        n_errors++;
        $error("result word with nothing expected: %h", out_word);
      end else begin
        want_word = expected_matches.pop_front();
        n_results++;
        if (want_word.found) n_found++;
        check_field("found", 64'(want_word.found), 64'(out_word.found));
        check_field("corner_index", 64'(want_word.corner_index), 64'(out_word.corner_index));
        check_field("match_x", 64'(want_word.match_x), 64'(out_word.match_x));
        check_field("match_y", 64'(want_word.match_y), 64'(out_word.match_y));
        check_field("run_done", 64'(want_word.run_done), 64'(out_word.run_done));
        check_field("all_matched", 64'(want_word.all_matched), 64'(out_word.all_matched));
      end
    end
  end

  // tracks clear and load; a match predicts the nearest unused corner strictly inside the gate, lowest index on ties
  task automatic predict_word(input in_word_t w);
    longint unsigned dx, dy, d, best_d;
    int best, n;
    bit hit;
    out_word_t r;
    case (w.action)
      ACT_CLEAR: begin
        corner_cnt = 0;
        run_aborted = 1'b0;
        for (n = 0; n < CORNERS; n++) corner_used[n] = 1'b0;
      end
      ACT_LOAD: begin
        if (corner_cnt < CORNERS) begin
          corner_x[corner_cnt] = w.point_x;
          corner_y[corner_cnt] = w.point_y;
          corner_cnt++;
        end
      end
      ACT_MATCH: begin
        hit = 1'b0;
        best = 0;
        best_d = 0;
        if (!run_aborted) begin
          for (n = 0; n < corner_cnt; n++) begin
            if (!corner_used[n]) begin
              dx = (w.point_x >= corner_x[n]) ? 64'(w.point_x - corner_x[n])
                                              : 64'(corner_x[n] - w.point_x);
              dy = (w.point_y >= corner_y[n]) ? 64'(w.point_y - corner_y[n])
                                              : 64'(corner_y[n] - w.point_y);
              d = dx * dx + dy * dy;
              if (d < 64'(gate_sqr) && (!hit || d < best_d)) begin
                hit = 1'b1;
                best = n;
                best_d = d;
              end
            end
          end
          if (hit) corner_used[best] = 1'b1;
          else run_aborted = 1'b1;
        end
        r = '0;
        r.found = hit;
        if (hit) begin
          r.corner_index = best[IDX_OUT_W-1:0];
          r.match_x = corner_x[best];
          r.match_y = corner_y[best];
        end
        r.run_done = w.last_point;
        r.all_matched = w.last_point && !run_aborted;
        expected_matches = {expected_matches, r};
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [1:0] act, input logic [FIELD_W-1:0] x,
                           input logic [FIELD_W-1:0] y, input logic last);
    in_word_t w;
    w = '{action: act, point_x: x, point_y: y, last_point: last};
    while (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_word(w);
    if (act != ACT_UNUSED) n_words++;
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_matches.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_gate(input logic [GATE_W-1:0] g);
    wait_idle(SETTLE);
    cfg_we <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    gate_sqr = g;
    n_gates++;
  endtask

  task automatic random_gate();
    case ($urandom_range(7))
      0: set_gate(GATE_W'($urandom_range(1 << 20)));
      1: set_gate({1'($urandom_range(1)), $urandom()});
      2: set_gate(GATE_W'($urandom_range(1 << 24)));
      3: set_gate('0);
      4: set_gate(GATE_ALL);
      default: set_gate(GATE_RESET);
    endcase
  endtask

  function automatic logic [FIELD_W-1:0] jitter(input logic [FIELD_W-1:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[FIELD_W-1:0];
  endfunction

  task automatic random_run(input int max_load);
    int n_load, n_match, k, pick, span;
    logic [FIELD_W-1:0] base_x, base_y, px, py;
    bit clustered;
    if ($urandom_range(9) != 0) begin
      send_word(ACT_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom_range(1)));
    end
    n_load = $urandom_range(max_load, 1);
    n_match = $urandom_range((n_load < 40) ? n_load + 1 : 40, 1);
    clustered = 1'($urandom_range(1));
    base_x = FIELD_W'($urandom);
    base_y = FIELD_W'($urandom);
    for (k = 0; k < n_load; k++) begin
      px = clustered ? base_x + FIELD_W'($urandom_range(1023)) : FIELD_W'($urandom);
      py = clustered ? base_y + FIELD_W'($urandom_range(1023)) : FIELD_W'($urandom);
      send_word(ACT_LOAD, px, py, 1'($urandom_range(1)));
    end
    for (k = 0; k < n_match; k++) begin
      if (corner_cnt == 0 || $urandom_range(9) == 0) begin
        px = FIELD_W'($urandom);
        py = FIELD_W'($urandom);
      end else begin
        pick = $urandom_range(corner_cnt - 1);
        case ($urandom_range(3))
          0: span = 0;
          1: span = 16;
          2: span = 255;
          default: span = 1024;
        endcase
        px = jitter(corner_x[pick], span);
        py = jitter(corner_y[pick], span);
      end
      send_word(ACT_MATCH, px, py, (k == n_match - 1) || ($urandom_range(19) == 0));
      if ($urandom_range(99) < 2) wait_idle(0);
    end
  endtask

  task automatic noise_burst();
    int k, n;
    n = $urandom_range(12, 1);
    for (k = 0; k < n; k++) begin
      send_word(2'($urandom_range(3)), FIELD_W'($urandom), FIELD_W'($urandom),
                1'($urandom_range(1)));
    end
  endtask

  task automatic test_directed();
    send_word(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(ACT_LOAD, 16'd0, 16'd0, 1'b0);
    send_word(ACT_LOAD, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(ACT_LOAD, 16'd100, 16'd100, 1'b0);
    send_word(ACT_LOAD, 16'd100, 16'd100, 1'b0);
    send_word(ACT_LOAD, 16'd1000, 16'd1000, 1'b0);
    send_word(ACT_MATCH, 16'd0, 16'd0, 1'b0);
    // equal distance to two corners
    send_word(ACT_MATCH, 16'd100, 16'd100, 1'b0);
    send_word(ACT_MATCH, 16'd100, 16'd100, 1'b0);
    // just inside the gate
    send_word(ACT_MATCH, 16'd1255, 16'd1000, 1'b0);
    send_word(ACT_MATCH, 16'hFFFF, 16'hFFFF, 1'b1);
    wait_idle(0);
    // store used up, then a match while aborted
    send_word(ACT_MATCH, 16'd5, 16'd5, 1'b0);
    send_word(ACT_MATCH, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
    send_word(ACT_LOAD, 16'd1000, 16'd1000, 1'b0);
    // distance exactly on the gate
    send_word(ACT_MATCH, 16'd1256, 16'd1000, 1'b1);
    send_word(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
    send_word(ACT_MATCH, 16'd0, 16'd0, 1'b1);
  endtask

  task automatic test_gate_extremes();
    set_gate('0);
    send_word(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
    send_word(ACT_LOAD, 16'd500, 16'd700, 1'b0);
    send_word(ACT_LOAD, 16'd0, 16'd0, 1'b0);
    send_word(ACT_MATCH, 16'd500, 16'd700, 1'b1);
    set_gate(GATE_ALL);
    send_word(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
    send_word(ACT_LOAD, 16'hFFFF, 16'hFFFF, 1'b0);
    send_word(ACT_LOAD, 16'd0, 16'hFFFF, 1'b0);
    send_word(ACT_MATCH, 16'd0, 16'd0, 1'b0);
    send_word(ACT_MATCH, 16'd0, 16'd0, 1'b1);
    set_gate(GATE_RESET);
  endtask

  task automatic test_full_store();
    int k;
    set_gate(GATE_ALL);
    send_word(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
    for (k = 0; k < CORNERS + 4; k++) begin
      send_word(ACT_LOAD, FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom_range(1)));
    end
    for (k = 0; k < 8; k++) send_word(ACT_MATCH, FIELD_W'($urandom), FIELD_W'($urandom), k == 7);
  endtask

  task automatic test_steady_stream();
    int k;
    gaps_on = 1'b0;
    set_gate(GATE_RESET);
    for (k = 0; k < 6; k++) random_run(24);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_runs();
    int r;
    r = 0;
    while (n_words < ITEM_TARGET) begin
      if (r % 8 == 7) random_gate();
      if ($urandom_range(99) < 15) noise_burst();
      else if ($urandom_range(99) < 3) random_run(CORNERS + 40);
      else random_run(24);
      r++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_gate_extremes();
    test_full_store();
    test_steady_stream();
    test_random_runs();
    wait_idle(SETTLE);
    $display("tb: %0d words accepted, %0d match results checked, %0d of them hits",
             n_words, n_results, n_found);
    $display("tb: %0d gate settings written, zero, full scale and reset value among them",
             n_gates);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
